// File: src/sqs_pkg.sv
// Shared types, constants and table functions for the sprite quad setup unit.
package sqs_pkg;

  localparam int CW = 40;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_CNT_W = 4;
  localparam int FIFO_PTR_W = 3;
  localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

  localparam logic [2:0] CFG_SHAKE_X = 3'd0;
  localparam logic [2:0] CFG_SHAKE_Y = 3'd1;
  localparam logic [2:0] CFG_VIEW_LEFT = 3'd2;
  localparam logic [2:0] CFG_VIEW_TOP = 3'd3;
  localparam logic [2:0] CFG_VIEW_WIDTH = 3'd4;
  localparam logic [2:0] CFG_VIEW_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_TINT_COLOR = 3'd6;
  localparam logic [2:0] CFG_TINT_ON = 3'd7;

  typedef enum logic [1:0] {
    ST_VERTEX = 2'd0,
    ST_NODRAW = 2'd1,
    ST_CULLED = 2'd2
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [3:0][15:0] vx;
    logic [3:0][15:0] vy;
    logic [15:0]      z;
    logic [15:0]      u0;
    logic [15:0]      u1;
    logic [15:0]      v0;
    logic [15:0]      v1;
    logic [31:0]      col;
  } entry_t;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_ctl_t;

  function automatic logic [63:0] div_pair(input logic [63:0] v, input logic [3:0] a);
    case (a)
      4'd1: return v / 2;
      4'd2: return v / 6;
      4'd3: return v / 12;
      4'd4: return v / 20;
      4'd5: return v / 30;
      4'd6: return v / 42;
      4'd7: return v / 56;
      4'd8: return v / 72;
      4'd9: return v / 90;
      4'd10: return v / 110;
      4'd11: return v / 132;
      4'd12: return v / 156;
      default: return v;
    endcase
  endfunction

  // Taylor series in Q28, result in Q14; used only to build the sine/cosine ROM.
  function automatic logic [14:0] trig_q14(input logic [63:0] x, input logic odd);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [3:0]         a;
    term = odd ? x : (64'd1 << 28);
    sum = signed'(term);
    for (int k = 1; k <= 6; k++) begin
      a = odd ? 4'(2 * k) : 4'(2 * k - 1);
      term = (term * x) >> 28;
      term = (term * x) >> 28;
      term = div_pair(term, a);
      if (k[0]) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 28)) sum = 64'sd1 <<< 28;
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 64'sd16384) sum = 64'sd16384;
    return sum[14:0];
  endfunction

endpackage

// File: src/sqs_front.sv
// Front end: accepts sprites, classifies them and computes the quad corners.
module sqs_front #(
  parameter int ANGLE_TABLE_BITS = 10,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [23:0]                    sprite_size,
  input  logic [31:0]                    scale_xy,
  input  logic [31:0]                    position_xy,
  input  logic [15:0]                    position_z,
  input  logic [15:0]                    angle,
  input  logic [7:0]                     mode_bits,
  input  logic [31:0]                    main_color,
  input  logic [31:0]                    alt_color,
  input  logic [63:0]                    uv_rect,
  input  logic [31:0]                    uv_scroll,
  input  logic [sqs_pkg::FIFO_CNT_W-1:0] fifo_count,
  output logic                           busy,
  output logic                           push,
  output sqs_pkg::entry_t                push_entry
);
  import sqs_pkg::*;

  localparam int TB = ANGLE_TABLE_BITS;
  localparam int QB = TB - 2;
  localparam int QN = 1 << QB;
  localparam int SH = 16 - COORD_FRAC_BITS;
  localparam logic signed [CW-1:0] OUT_MIN = CW'(-32768);
  localparam logic signed [CW-1:0] OUT_MAX = CW'(32767);

  typedef struct packed {
    logic [15:0] z;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [15:0] v0;
    logic [15:0] v1;
    logic [31:0] col;
    logic        nd;
    logic        rot;
    logic        ax;
    logic        ay;
    logic        rnd;
  } side_t;

  logic signed [15:0] shake_x, shake_y;
  logic [11:0] view_left, view_top, view_width, view_height;
  logic [31:0] tint_color;
  logic        tint_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      shake_x <= '0;
      shake_y <= '0;
      view_left <= '0;
      view_top <= '0;
      view_width <= 12'd640;
      view_height <= 12'd480;
      tint_color <= 32'h8080_8080;
      tint_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHAKE_X: shake_x <= signed'(cfg_data[15:0]);
        CFG_SHAKE_Y: shake_y <= signed'(cfg_data[15:0]);
        CFG_VIEW_LEFT: view_left <= cfg_data[11:0];
        CFG_VIEW_TOP: view_top <= cfg_data[11:0];
        CFG_VIEW_WIDTH: view_width <= cfg_data[11:0];
        CFG_VIEW_HEIGHT: view_height <= cfg_data[11:0];
        CFG_TINT_COLOR: tint_color <= cfg_data;
        CFG_TINT_ON: tint_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine/cosine ROM
  logic [14:0] rom_s [QN];
  logic [14:0] rom_c [QN];
  for (genvar i = 0; i < QN; i++) begin : g_rom
    localparam logic [63:0] XA = (64'(i) * TWO_PI_Q28) >> TB;
    localparam logic [14:0] SV = trig_q14(XA, 1'b1);
    localparam logic [14:0] CV = trig_q14(XA, 1'b0);
    assign rom_s[i] = SV;
    assign rom_c[i] = CV;
  end

  logic v1, v2, v3, v4, v5;
  logic accept;
  logic [2:0] inflight;

  assign inflight = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4) + 3'(v5);
  assign busy = ({1'b0, fifo_count} + 5'(inflight)) >= 5'(FIFO_DEPTH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 0: decode, extents, tint, uv, table read
  logic [27:0] hxp, hyp;
  logic [TB-1:0] aidx;
  side_t side0;
  logic [31:0] csel, ctint;
  logic [15:0] us, vs, ue, ve;

  always_comb begin
    logic [15:0] prod;
    hxp = 28'(sprite_size[11:0]) * 28'(scale_xy[15:0]);
    hyp = 28'(sprite_size[23:12]) * 28'(scale_xy[31:16]);
    aidx = angle[15 -: TB];
    csel = mode_bits[7] ? alt_color : main_color;
    for (int b = 0; b < 4; b++) begin
      prod = 16'(csel[8*b +: 8]) * 16'(tint_color[8*b +: 8]);
      ctint[8*b +: 8] = prod[15] ? 8'hFF : prod[14:7];
    end
    us = uv_rect[15:0];
    vs = uv_rect[31:16];
    ue = uv_rect[47:32];
    ve = uv_rect[63:48];
    side0.z = position_z;
    side0.u0 = (mode_bits[5] ? ue : us) + uv_scroll[15:0];
    side0.u1 = (mode_bits[5] ? us : ue) + uv_scroll[15:0];
    side0.v0 = vs + uv_scroll[31:16];
    side0.v1 = ve + uv_scroll[31:16];
    side0.col = tint_on ? ctint : csel;
    side0.nd = (mode_bits[1:0] != 2'b11) || !mode_bits[2] || (main_color[31:24] == 8'd0);
    side0.rot = (angle != 16'd0);
    side0.ax = mode_bits[3];
    side0.ay = mode_bits[4];
    side0.rnd = mode_bits[6];
  end

  logic [30:0] hx1, hy1;
  logic signed [15:0] px1, py1;
  logic [14:0] sraw1, craw1;
  logic [1:0] q1;
  side_t side1;

  always_ff @(posedge clk) begin
    if (accept) begin
      hx1 <= {hxp, 3'b000};
      hy1 <= {hyp, 3'b000};
      px1 <= signed'(position_xy[15:0]);
      py1 <= signed'(position_xy[31:16]);
      sraw1 <= rom_s[aidx[QB-1:0]];
      craw1 <= rom_c[aidx[QB-1:0]];
      q1 <= aidx[TB-1 -: 2];
      side1 <= side0;
    end
  end

  // stage 1: quadrant fold and rotation products
  logic signed [15:0] s1, c1, sp, cp;
  always_comb begin
    sp = signed'({1'b0, sraw1});
    cp = signed'({1'b0, craw1});
    case (q1)
      2'd0: begin
        s1 = sp;
        c1 = cp;
      end
      2'd1: begin
        s1 = cp;
        c1 = -sp;
      end
      2'd2: begin
        s1 = -sp;
        c1 = -cp;
      end
      default: begin
        s1 = -cp;
        c1 = sp;
      end
    endcase
  end

  logic signed [47:0] pa2, pb2, pc2, pd2;
  logic [30:0] hx2, hy2;
  logic signed [15:0] px2, py2;
  side_t side2;

  always_ff @(posedge clk) begin
    pa2 <= signed'({1'b0, hx1}) * c1;
    pb2 <= signed'({1'b0, hy1}) * s1;
    pc2 <= signed'({1'b0, hx1}) * s1;
    pd2 <= signed'({1'b0, hy1}) * c1;
    hx2 <= hx1;
    hy2 <= hy1;
    px2 <= px1;
    py2 <= py1;
    side2 <= side1;
  end

  // stage 2: corners plus shake
  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cy [4];
  always_comb begin
    logic signed [CW-1:0] pxw, pyw, hxw, hyw, shx, shy, lx, rx, ty, by;
    logic signed [47:0] ta, tb, tc, td;
    pxw = CW'(px2) <<< SH;
    pyw = CW'(py2) <<< SH;
    hxw = CW'({1'b0, hx2});
    hyw = CW'({1'b0, hy2});
    shx = CW'(shake_x) <<< SH;
    shy = CW'(shake_y) <<< SH;
    lx = side2.ax ? pxw : pxw - hxw;
    rx = side2.ax ? pxw + (hxw <<< 1) : pxw + hxw;
    ty = side2.ay ? pyw : pyw - hyw;
    by = side2.ay ? pyw + (hyw <<< 1) : pyw + hyw;
    for (int n = 0; n < 4; n++) begin
      ta = n[0] ? pa2 : -pa2;
      tb = n[1] ? pb2 : -pb2;
      tc = n[0] ? pc2 : -pc2;
      td = n[1] ? pd2 : -pd2;
      if (side2.rot) begin
        cx[n] = CW'((ta - tb) >>> 14) + pxw + (side2.ax ? hxw : '0) + shx;
        cy[n] = CW'((tc + td) >>> 14) + pyw + (side2.ay ? hyw : '0) + shy;
      end else begin
        cx[n] = (n[0] ? rx : lx) + shx;
        cy[n] = (n[1] ? by : ty) + shy;
      end
    end
  end

  logic signed [CW-1:0] x3 [4];
  logic signed [CW-1:0] y3 [4];
  side_t side3;

  always_ff @(posedge clk) begin
    x3 <= cx;
    y3 <= cy;
    side3 <= side2;
  end

  // stage 3: snap to round-half-even minus one half
  function automatic logic signed [CW-1:0] snap(input logic signed [CW-1:0] v);
    logic signed [CW-17:0] ip;
    logic inc;
    ip = v[CW-1:16];
    inc = (v[15:0] > 16'h8000) || ((v[15:0] == 16'h8000) && ip[0]);
    return signed'({inc ? ip : ip - 1'b1, 16'h8000});
  endfunction

  logic signed [CW-1:0] x4 [4];
  logic signed [CW-1:0] y4 [4];
  side_t side4;
  logic do_snap;
  assign do_snap = !side3.rot && side3.rnd;

  always_ff @(posedge clk) begin
    for (int n = 0; n < 4; n++) begin
      x4[n] <= do_snap ? snap(x3[n]) : x3[n];
      y4[n] <= do_snap ? snap(y3[n]) : y3[n];
    end
    side4 <= side3;
  end

  // stage 4: bounds and output conversion
  function automatic logic [15:0] to_out(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] o;
    o = v >>> SH;
    if (o < OUT_MIN) return 16'h8000;
    if (o > OUT_MAX) return 16'h7FFF;
    return o[15:0];
  endfunction

  logic signed [CW-1:0] mnx, mxx, mny, mxy;
  always_comb begin
    mnx = x4[0];
    mxx = x4[0];
    mny = y4[0];
    mxy = y4[0];
    for (int n = 1; n < 4; n++) begin
      if (x4[n] < mnx) mnx = x4[n];
      if (x4[n] > mxx) mxx = x4[n];
      if (y4[n] < mny) mny = y4[n];
      if (y4[n] > mxy) mxy = y4[n];
    end
  end

  logic signed [CW-1:0] mnx5, mxx5, mny5, mxy5;
  logic [3:0][15:0] ox5, oy5;
  side_t side5;

  always_ff @(posedge clk) begin
    mnx5 <= mnx;
    mxx5 <= mxx;
    mny5 <= mny;
    mxy5 <= mxy;
    for (int n = 0; n < 4; n++) begin
      ox5[n] <= to_out(x4[n]);
      oy5[n] <= to_out(y4[n]);
    end
    side5 <= side4;
  end

  // stage 5: viewport cull and queue write
  logic signed [CW-1:0] vl, vt, vr, vb;
  logic culled;
  always_comb begin
    vl = CW'({view_left, 16'h0000});
    vt = CW'({view_top, 16'h0000});
    vr = CW'({13'(view_left) + 13'(view_width), 16'h0000});
    vb = CW'({13'(view_top) + 13'(view_height), 16'h0000});
    culled = (mxx5 < vl) || (mxy5 < vt) || (mnx5 > vr) || (mny5 > vb);
    push = v5;
    push_entry = '0;
    if (side5.nd) begin
      push_entry.status = ST_NODRAW;
    end else if (culled) begin
      push_entry.status = ST_CULLED;
    end else begin
      push_entry.status = ST_VERTEX;
      push_entry.vx = ox5;
      push_entry.vy = oy5;
      push_entry.z = side5.z;
      push_entry.u0 = side5.u0;
      push_entry.u1 = side5.u1;
      push_entry.v0 = side5.v0;
      push_entry.v1 = side5.v1;
      push_entry.col = side5.col;
    end
  end

endmodule

// File: src/sqs_fifo.sv
// Short queue of finished quads between the front and back ends.
module sqs_fifo (
  input  logic                clk,
  input  logic                rst,
  input  sqs_pkg::fifo_ctl_t  ctl_in,
  input  sqs_pkg::entry_t     wr_entry,
  output sqs_pkg::entry_t     rd_entry,
  output logic                empty,
  output logic [sqs_pkg::FIFO_CNT_W-1:0] count
);
  import sqs_pkg::*;

  entry_t mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr, rptr;
  logic full;

  assign empty = (count == '0);
  assign full = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (ctl_in.push) mem[wptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (ctl_in.push) wptr <= wptr + 1'b1;
      if (ctl_in.pop) rptr <= rptr + 1'b1;
      count <= count + FIFO_CNT_W'(ctl_in.push) - FIFO_CNT_W'(ctl_in.pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(ctl_in.push && full && !ctl_in.pop)) else $error("quad queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(ctl_in.pop && empty)) else $error("quad queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ctl_in.push && !ctl_in.pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");

endmodule

// File: src/sqs_back.sv
// Back end: walks each queued quad out as four vertices or one status item.
module sqs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  sqs_pkg::entry_t head,
  output logic            pop,
  output logic            done,
  output logic [15:0]     vertex_x,
  output logic [15:0]     vertex_y,
  output logic [15:0]     vertex_z,
  output logic [15:0]     tex_u,
  output logic [15:0]     tex_v,
  output logic [31:0]     vertex_color,
  output logic [1:0]      status,
  output logic            last
);
  import sqs_pkg::*;

  entry_t cur;
  logic active;
  logic [1:0] idx;

  assign done = active;
  assign last = active && ((cur.status != ST_VERTEX) || (idx == 2'd3));
  assign pop = !empty && (!active || last);

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx <= '0;
    end else if (last) begin
      active <= 1'b0;
    end else if (active) begin
      idx <= idx + 1'b1;
    end
  end

  assign vertex_x = cur.vx[idx];
  assign vertex_y = cur.vy[idx];
  assign vertex_z = cur.z;
  assign tex_u = idx[0] ? cur.u1 : cur.u0;
  assign tex_v = idx[1] ? cur.v1 : cur.v0;
  assign vertex_color = cur.col;
  assign status = cur.status;

  a_quad_runs: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && (idx == $past(idx) + 2'd1)) else $error("quad broken off");
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    done && (cur.status != ST_VERTEX) |-> last && (idx == 2'd0))
    else $error("status item not single");
  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    done && last && !empty |-> pop) else $error("queue head left waiting");

endmodule

// File: src/sprite_quad_setup_unit.sv
// Top level of the sprite quad setup unit.
// A sprite's first result reaches the ports after the front pipeline registers, the quad queue
// and the back end's current-quad register.
// Throughput is set by the back end's single result port: one result each cycle while the
// queue holds entries, four vertices per drawn quad and one status item per status-only sprite.
// busy rises once the 5-stage front pipeline and the 8-deep quad queue together hold 8 sprites.
// rst (synchronous) empties the pipeline and queue and restores the register defaults.
module sprite_quad_setup_unit #(
  parameter int ANGLE_TABLE_BITS = 10,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [23:0] sprite_size,
  input  logic [31:0] scale_xy,
  input  logic [31:0] position_xy,
  input  logic [15:0] position_z,
  input  logic [15:0] angle,
  input  logic [7:0]  mode_bits,
  input  logic [31:0] main_color,
  input  logic [31:0] alt_color,
  input  logic [63:0] uv_rect,
  input  logic [31:0] uv_scroll,
  output logic        done,
  output logic [15:0] vertex_x,
  output logic [15:0] vertex_y,
  output logic [15:0] vertex_z,
  output logic [15:0] tex_u,
  output logic [15:0] tex_v,
  output logic [31:0] vertex_color,
  output logic [1:0]  status,
  output logic        last
);
  import sqs_pkg::*;

  fifo_ctl_t ctl;
  entry_t wr_entry, head;
  logic push, pop, empty;
  logic [FIFO_CNT_W-1:0] count;

  assign ctl.push = push;
  assign ctl.pop = pop;
  assign ctl.empty = empty;
  assign ctl.count = count;

  sqs_front #(
    .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sprite_size(sprite_size),
    .scale_xy(scale_xy),
    .position_xy(position_xy),
    .position_z(position_z),
    .angle(angle),
    .mode_bits(mode_bits),
    .main_color(main_color),
    .alt_color(alt_color),
    .uv_rect(uv_rect),
    .uv_scroll(uv_scroll),
    .fifo_count(ctl.count),
    .busy(busy),
    .push(push),
    .push_entry(wr_entry)
  );

  sqs_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .ctl_in(ctl),
    .wr_entry(wr_entry),
    .rd_entry(head),
    .empty(empty),
    .count(count)
  );

  sqs_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(ctl.empty),
    .head(head),
    .pop(pop),
    .done(done),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .vertex_z(vertex_z),
    .tex_u(tex_u),
    .tex_v(tex_v),
    .vertex_color(vertex_color),
    .status(status),
    .last(last)
  );

endmodule

// File: tb/sv/tb_sprite_quad_setup_unit.sv
// Self-checking testbench for sprite_quad_setup_unit: directed table plus random sprites.
`timescale 1ns / 1ps

module tb_sprite_quad_setup_unit;
  import sqs_pkg::*;

  localparam longint ONE_Q16 = 65536;
  localparam longint POS_UP = 4096;
  localparam logic [63:0] TURN_Q28 = 64'd1686629713;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [23:0] size;
    logic [31:0] scale;
    logic [31:0] pos;
    logic [15:0] z;
    logic [15:0] ang;
    logic [7:0]  mode;
    logic [31:0] mainc;
    logic [31:0] altc;
    logic [63:0] uv;
    logic [31:0] scroll;
  } sprite_t;

  typedef struct {
    sprite_t spr;
    bit      fixed;
    status_t fixed_st;
  } dir_row_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] u;
    logic [15:0] v;
    logic [31:0] col;
    logic [1:0]  st;
    logic        lst;
  } vertex_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [23:0] sprite_size = '0;
  logic [31:0] scale_xy = '0;
  logic [31:0] position_xy = '0;
  logic [15:0] position_z = '0;
  logic [15:0] angle = '0;
  logic [7:0]  mode_bits = '0;
  logic [31:0] main_color = '0;
  logic [31:0] alt_color = '0;
  logic [63:0] uv_rect = '0;
  logic [31:0] uv_scroll = '0;
  logic        done;
  logic [15:0] vertex_x, vertex_y, vertex_z, tex_u, tex_v;
  logic [31:0] vertex_color;
  logic [1:0]  status;
  logic        last;

  sprite_quad_setup_unit uut (.*);

  longint      shake_x_m, shake_y_m;
  longint      view_l_m, view_t_m, view_w_m, view_h_m;
  logic [31:0] tint_m;
  logic        tint_on_m;

  vertex_t     vertex_q[$];
  int          errors = 0;
  int          cycles = 0;
  dir_row_t    dir_tab[$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && done) begin
      if (vertex_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex st=%0d x=%h", status, vertex_x);
      end else begin
        e = vertex_q.pop_front();
        if (e.x !== vertex_x || e.y !== vertex_y || e.z !== vertex_z || e.u !== tex_u ||
            e.v !== tex_v || e.col !== vertex_color || e.st !== status || e.lst !== last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp x%h y%h z%h u%h v%h c%h s%0d l%0d",
                     e.x, e.y, e.z, e.u, e.v, e.col, e.st, e.lst);
            $display("         got x%h y%h z%h u%h v%h c%h s%0d l%0d",
                     vertex_x, vertex_y, vertex_z, tex_u, tex_v, vertex_color, status, last);
          end
        end
      end
    end
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint taylor_q14(logic [63:0] x, bit odd);
    logic [63:0] term;
    longint      sum;
    logic [63:0] a;
    term = odd ? x : (64'd1 << 28);
    sum = longint'(term);
    for (int k = 1; k <= 6; k++) begin
      a = odd ? 64'(2 * k) : 64'(2 * k - 1);
      term = (term * x) >> 28;
      term = ((term * x) >> 28) / (a * (a + 1));
      if (k % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 28)) sum = 64'sd1 <<< 28;
    sum = (sum + 8192) >>> 14;
    return sum > 16384 ? 16384 : sum;
  endfunction

  function automatic longint snap_coord(longint v);
    longint ip, frac;
    ip = v >>> 16;
    frac = v - ip * ONE_Q16;
    if (frac > 32768 || (frac == 32768 && ip[0])) ip++;
    return ip * ONE_Q16 - 32768;
  endfunction

  function automatic logic [15:0] out_coord(longint v);
    longint o;
    o = v >>> 12;
    if (o < -32768) o = -32768;
    if (o > 32767) o = 32767;
    return o[15:0];
  endfunction

  function automatic logic [31:0] tint_color_of(logic [31:0] c);
    logic [31:0] r;
    logic [15:0] p;
    if (!tint_on_m) return c;
    for (int b = 0; b < 4; b++) begin
      p = (16'(c[8*b +: 8]) * 16'(tint_m[8*b +: 8])) >> 7;
      r[8*b +: 8] = p > 255 ? 8'd255 : p[7:0];
    end
    return r;
  endfunction

  task automatic push_status(status_t st);
    vertex_t e;
    e = '{default: '0};
    e.st = st;
    e.lst = 1;
    vertex_q.insert(vertex_q.size(), e);
  endtask

  task automatic predict_quad(sprite_t s);
    longint hx, hy, px, py, sn, cs, sv, cv, cx, cy, l, r, t, b;
    longint vx[4], vy[4], minx, maxx, miny, maxy;
    logic [9:0]  idx;
    logic [63:0] xr;
    logic [15:0] u0, u1, v0, v1;
    logic [31:0] col;
    vertex_t e;
    if (s.mode[1:0] != 2'b11 || !s.mode[2] || s.mainc[31:24] == 0) begin
      push_status(ST_NODRAW);
      return;
    end
    hx = longint'(s.size[11:0]) * longint'(s.scale[15:0]) * 8;
    hy = longint'(s.size[23:12]) * longint'(s.scale[31:16]) * 8;
    px = sx16(s.pos[15:0]) * POS_UP;
    py = sx16(s.pos[31:16]) * POS_UP;
    if (s.ang != 0) begin
      idx = s.ang[15:6];
      xr = (64'(idx[7:0]) * TURN_Q28) >> 10;
      sv = taylor_q14(xr, 1);
      cv = taylor_q14(xr, 0);
      case (idx[9:8])
        2'd0: begin sn = sv; cs = cv; end
        2'd1: begin sn = cv; cs = -sv; end
        2'd2: begin sn = -sv; cs = -cv; end
        default: begin sn = -cv; cs = sv; end
      endcase
      for (int n = 0; n < 4; n++) begin
        cx = n[0] ? hx : -hx;
        cy = n[1] ? hy : -hy;
        vx[n] = ((cx * cs - cy * sn) >>> 14) + px + (s.mode[3] ? hx : 0);
        vy[n] = ((cx * sn + cy * cs) >>> 14) + py + (s.mode[4] ? hy : 0);
      end
    end else begin
      l = s.mode[3] ? px : px - hx;
      r = s.mode[3] ? px + 2 * hx : px + hx;
      t = s.mode[4] ? py : py - hy;
      b = s.mode[4] ? py + 2 * hy : py + hy;
      vx = '{l, r, l, r};
      vy = '{t, t, b, b};
    end
    for (int n = 0; n < 4; n++) begin
      vx[n] += shake_x_m * POS_UP;
      vy[n] += shake_y_m * POS_UP;
    end
    if (s.ang == 0 && s.mode[6]) begin
      l = snap_coord(vx[0]);
      r = snap_coord(vx[1]);
      t = snap_coord(vy[0]);
      b = snap_coord(vy[2]);
      vx = '{l, r, l, r};
      vy = '{t, t, b, b};
    end
    minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0];
    for (int n = 1; n < 4; n++) begin
      if (vx[n] < minx) minx = vx[n];
      if (vx[n] > maxx) maxx = vx[n];
      if (vy[n] < miny) miny = vy[n];
      if (vy[n] > maxy) maxy = vy[n];
    end
    if (maxx < view_l_m * ONE_Q16 || maxy < view_t_m * ONE_Q16 ||
        minx > (view_l_m + view_w_m) * ONE_Q16 || miny > (view_t_m + view_h_m) * ONE_Q16) begin
      push_status(ST_CULLED);
      return;
    end
    u0 = (s.mode[5] ? s.uv[47:32] : s.uv[15:0]) + s.scroll[15:0];
    u1 = (s.mode[5] ? s.uv[15:0] : s.uv[47:32]) + s.scroll[15:0];
    v0 = s.uv[31:16] + s.scroll[31:16];
    v1 = s.uv[63:48] + s.scroll[31:16];
    col = tint_color_of(s.mode[7] ? s.altc : s.mainc);
    for (int n = 0; n < 4; n++) begin
      e.x = out_coord(vx[n]);
      e.y = out_coord(vy[n]);
      e.z = s.z;
      e.u = n[0] ? u1 : u0;
      e.v = n[1] ? v1 : v0;
      e.col = col;
      e.st = ST_VERTEX;
      e.lst = (n == 3);
      vertex_q.insert(vertex_q.size(), e);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_SHAKE_X: shake_x_m = sx16(val[15:0]);
      CFG_SHAKE_Y: shake_y_m = sx16(val[15:0]);
      CFG_VIEW_LEFT: view_l_m = val[11:0];
      CFG_VIEW_TOP: view_t_m = val[11:0];
      CFG_VIEW_WIDTH: view_w_m = val[11:0];
      CFG_VIEW_HEIGHT: view_h_m = val[11:0];
      CFG_TINT_COLOR: tint_m = val;
      CFG_TINT_ON: tint_on_m = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    wait (vertex_q.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  // start stays high across back-to-back items; drops only when idling
  task automatic send_sprite(sprite_t s, int idle_pct, bit fixed, status_t fst);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    sprite_size = s.size; scale_xy = s.scale; position_xy = s.pos; position_z = s.z;
    angle = s.ang; mode_bits = s.mode; main_color = s.mainc; alt_color = s.altc;
    uv_rect = s.uv; uv_scroll = s.scroll;
    start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (fixed) push_status(fst);
    else predict_quad(s);
  endtask

  function automatic sprite_t rand_sprite(bit clean);
    sprite_t s;
    s.size = 24'($urandom);
    s.scale = $urandom;
    s.pos = $urandom;
    s.z = 16'($urandom);
    s.ang = 16'($urandom);
    s.mode = 8'($urandom);
    s.mainc = $urandom;
    s.altc = $urandom;
    s.uv = {$urandom, $urandom};
    s.scroll = $urandom;
    if (clean) begin
      s.size = {12'($urandom_range(0, 80)), 12'($urandom_range(0, 80))};
      if ($urandom_range(0, 19) == 0) s.size = 24'($urandom);
      s.scale = {16'($urandom_range(0, 16'h3000)), 16'($urandom_range(0, 16'h3000))};
      s.pos = {16'($urandom_range(0, 16'h2000) - 16'h0400),
               16'($urandom_range(0, 16'h2c00) - 16'h0400)};
      if ($urandom_range(0, 1)) s.ang = 0;
      s.mode[2:0] = 3'b111;
      if (s.mainc[31:24] == 0) s.mainc[31:24] = 8'h01;
    end
    return s;
  endfunction

  function automatic sprite_t base_sprite();
    sprite_t s;
    s.size = {12'd16, 12'd32};
    s.scale = {16'h1000, 16'h1000};
    s.pos = {16'd1600, 16'd1600};
    s.z = 16'h1234;
    s.ang = 0;
    s.mode = 8'b0000_0111;
    s.mainc = 32'hFF80_40C0;
    s.altc = 32'h1122_3344;
    s.uv = 64'h0400_0300_0200_0100;
    s.scroll = 32'h0010_0020;
    return s;
  endfunction

  task automatic add_row(sprite_t s, bit fixed = 0, status_t st = ST_VERTEX);
    dir_row_t r;
    r.spr = s;
    r.fixed = fixed;
    r.fixed_st = st;
    dir_tab.insert(dir_tab.size(), r);
  endtask

  initial begin
    sprite_t s;
    int idle_pct[3] = '{0, 85, 25};

    shake_x_m = 0; shake_y_m = 0; view_l_m = 0; view_t_m = 0;
    view_w_m = 640; view_h_m = 480; tint_m = 32'h8080_8080; tint_on_m = 0;

    s = base_sprite(); add_row(s);
    s = base_sprite(); s.mode[1:0] = 2'b01; add_row(s, 1, ST_NODRAW);
    s = base_sprite(); s.mode[1:0] = 2'b10; add_row(s, 1, ST_NODRAW);
    s = base_sprite(); s.mode[2] = 0; add_row(s, 1, ST_NODRAW);
    s = base_sprite(); s.mainc[31:24] = 0; add_row(s, 1, ST_NODRAW);
    s = base_sprite(); s.pos = {16'h0000, 16'h8000}; add_row(s, 1, ST_CULLED);
    s = base_sprite(); s.pos = {16'h7FFF, 16'h0000}; add_row(s, 1, ST_CULLED);
    s = base_sprite(); s.mode[4:3] = 2'b11; add_row(s);
    s = base_sprite(); s.mode[5] = 1; add_row(s);
    s = base_sprite(); s.mode[6] = 1; s.pos = {16'd1608, 16'd1592}; add_row(s);
    s = base_sprite(); s.mode[6] = 1; s.pos = {16'd1640, 16'd1624}; add_row(s);
    s = base_sprite(); s.mode[7] = 1; add_row(s);
    s = base_sprite(); s.ang = 16'h4000; add_row(s);
    s = base_sprite(); s.ang = 16'hFFFF; s.mode[6] = 1; add_row(s);
    s = base_sprite(); s.ang = 16'h8000; s.mode[4:3] = 2'b01; add_row(s);
    s = base_sprite(); s.ang = 16'h0040; s.mode[4:3] = 2'b10; add_row(s);
    s = base_sprite(); s.size = 24'hFFFFFF; s.scale = 32'hFFFFFFFF; add_row(s);
    s = base_sprite(); s.size = 0; s.scale = 0; add_row(s);
    s = base_sprite(); s.uv = 64'hFFFF_FFFF_FFFF_FFFF; s.scroll = 32'hFFFF_FFFF; add_row(s);
    s = base_sprite(); s.z = 16'hFFFF; s.mode = 8'hFF; s.altc = 32'hFFFF_FFFF; add_row(s);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_tab[i]) send_sprite(dir_tab[i].spr, 0, dir_tab[i].fixed, dir_tab[i].fixed_st);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      if (ph == 1) begin
        write_reg(CFG_SHAKE_X, $urandom_range(0, 1023) - 512);
        write_reg(CFG_SHAKE_Y, $urandom_range(0, 1023) - 512);
        write_reg(CFG_VIEW_LEFT, $urandom_range(0, 200));
        write_reg(CFG_VIEW_TOP, $urandom_range(0, 200));
        write_reg(CFG_VIEW_WIDTH, $urandom_range(100, 700));
        write_reg(CFG_VIEW_HEIGHT, $urandom_range(100, 700));
        write_reg(CFG_TINT_COLOR, $urandom);
        write_reg(CFG_TINT_ON, 1);
      end else if (ph == 2) begin
        write_reg(CFG_SHAKE_X, 32'h0000_8000);
        write_reg(CFG_SHAKE_Y, 32'h0000_7FFF);
        write_reg(CFG_VIEW_LEFT, 0);
        write_reg(CFG_VIEW_TOP, 0);
        write_reg(CFG_VIEW_WIDTH, 4095);
        write_reg(CFG_VIEW_HEIGHT, 4095);
        write_reg(CFG_TINT_COLOR, 32'hFFFF_FFFF);
        write_reg(CFG_TINT_ON, 1);
      end
      for (int i = 0; i < 145; i++) begin
        if (i == 70) drain();
        send_sprite(rand_sprite($urandom_range(0, 3) != 0),
                    (i % 50 < 10) ? 0 : idle_pct[ph], 0, ST_VERTEX);
      end
    end

    drain();
    write_reg(CFG_TINT_ON, 0);
    write_reg(CFG_VIEW_LEFT, 4095);
    write_reg(CFG_VIEW_TOP, 4095);
    write_reg(CFG_VIEW_WIDTH, 0);
    write_reg(CFG_VIEW_HEIGHT, 0);
    for (int i = 0; i < 20; i++) send_sprite(rand_sprite($urandom_range(0, 1)), 25, 0, ST_VERTEX);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
